// ----- design/i2cm_pkg.sv -----
// Shared types, bus phase codes and line-level decode for the I2C register master.
package i2cm_pkg;

  localparam int unsigned PhaseW = 6;

  localparam logic [PhaseW-1:0] PH_IDLE = 6'd0;
  localparam logic [PhaseW-1:0] PH_ST1  = 6'd1;
  localparam logic [PhaseW-1:0] PH_ST2  = 6'd2;
  localparam logic [PhaseW-1:0] PH_ST3  = 6'd3;
  localparam logic [PhaseW-1:0] PH_RS1  = 6'd4;
  localparam logic [PhaseW-1:0] PH_RS2  = 6'd5;
  localparam logic [PhaseW-1:0] PH_RS3  = 6'd6;
  localparam logic [PhaseW-1:0] PH_RS4  = 6'd7;
  localparam logic [PhaseW-1:0] PH_SEND = 6'd8;
  localparam logic [PhaseW-1:0] PH_RLO  = 6'd24;
  localparam logic [PhaseW-1:0] PH_RHI  = 6'd25;
  localparam logic [PhaseW-1:0] PH_MLO  = 6'd26;
  localparam logic [PhaseW-1:0] PH_MHI  = 6'd27;
  localparam logic [PhaseW-1:0] PH_MEND = 6'd28;
  localparam logic [PhaseW-1:0] PH_P1   = 6'd29;
  localparam logic [PhaseW-1:0] PH_P2   = 6'd30;
  localparam logic [PhaseW-1:0] PH_P3   = 6'd31;
  localparam logic [PhaseW-1:0] PH_E1   = 6'd32;
  localparam logic [PhaseW-1:0] PH_E2   = 6'd33;
  localparam logic [PhaseW-1:0] PH_E3   = 6'd34;

  // byte slots inside the send window, four phases per slot group
  localparam logic [1:0] SLOT_DEV  = 2'd0;
  localparam logic [1:0] SLOT_REG  = 2'd1;
  localparam logic [1:0] SLOT_DATA = 2'd2;

  // position inside one bit cell of the send window
  localparam logic [1:0] BIT_LO  = 2'd0;
  localparam logic [1:0] BIT_HI  = 2'd1;
  localparam logic [1:0] ACK_LO  = 2'd2;
  localparam logic [1:0] ACK_HI  = 2'd3;

  localparam logic       ACT_CMD  = 1'b0;
  localparam logic       ACT_TICK = 1'b1;

  localparam logic [1:0] ST_NONE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ABORT = 2'd2;

  localparam logic [9:0] ACK_TIMEOUT_RESET = 10'd1000;
  localparam logic [7:0] MSB_MASK          = 8'h80;

  typedef struct packed {
    logic       action;
    logic       is_read;
    logic [7:0] slave_addr;
    logic [7:0] reg_ptr;
    logic [7:0] write_data;
    logic [7:0] byte_count;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       last_byte;
    logic       busy_res;
    logic [1:0] status;
  } out_item_t;

  // returns {scl, sda} driven in a given phase
  function automatic logic [1:0] bus_levels(logic [PhaseW-1:0] ph, logic data_bit, logic ack);
    logic [PhaseW-1:0] sub;
    logic [1:0]        lv;
    sub = ph - PH_SEND;
    lv  = 2'b11;
    if (ph >= PH_SEND && ph < PH_RLO) begin
      unique case (sub[1:0])
        BIT_LO:  lv = {1'b0, data_bit};
        BIT_HI:  lv = {1'b1, data_bit};
        ACK_LO:  lv = 2'b01;
        default: lv = 2'b11;
      endcase
    end else begin
      unique case (ph)
        PH_ST2, PH_RS3, PH_P2, PH_E2: lv = 2'b10;
        PH_ST3, PH_RS4, PH_P1, PH_E1: lv = 2'b00;
        PH_RS1, PH_RLO:               lv = 2'b01;
        PH_MLO, PH_MEND:              lv = {1'b0, ack};
        PH_MHI:                       lv = {1'b1, ack};
        default:                      lv = 2'b11;
      endcase
    end
    return lv;
  endfunction

endpackage

// ----- design/i2cm_engine.sv -----
// Bus phase sequencer: transaction state registers and the per-item step logic.
module i2cm_engine
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_we,
  input  logic [9:0] cfg_wdata,
  input  logic      step_en,
  input  in_item_t  item,
  output out_item_t result
);

  logic [PhaseW-1:0] phase_r, phase_nxt;
  logic [3:0]        bit_index_r, bit_index_nxt;
  logic [7:0]        shift_byte_r, shift_byte_nxt;
  logic [7:0]        bytes_left_r, bytes_left_nxt;
  logic [9:0]        wait_count_r, wait_count_nxt;
  logic [7:0]        saved_device_r, saved_device_nxt;
  logic [7:0]        saved_register_r, saved_register_nxt;
  logic [7:0]        saved_data_r, saved_data_nxt;
  logic              saved_is_read_r, saved_is_read_nxt;
  logic [9:0]        ack_timeout_r;

  logic [PhaseW-1:0] send_off;
  logic [1:0]        slot;
  logic [1:0]        bit_pos;
  logic [10:0]       wait_inc;
  logic [7:0]        rx_shift;
  logic              last_left;
  logic [1:0]        lv;

  assign send_off  = phase_r - PH_SEND;
  assign slot      = send_off[3:2];
  assign bit_pos   = send_off[1:0];
  assign wait_inc  = {1'b0, wait_count_r} + 11'd1;
  assign rx_shift  = {shift_byte_r[6:0], item.sda_in};
  assign last_left = (bytes_left_r <= 8'd1);

  always_comb begin
    phase_nxt          = phase_r;
    bit_index_nxt      = bit_index_r;
    shift_byte_nxt     = shift_byte_r;
    bytes_left_nxt     = bytes_left_r;
    wait_count_nxt     = wait_count_r;
    saved_device_nxt   = saved_device_r;
    saved_register_nxt = saved_register_r;
    saved_data_nxt     = saved_data_r;
    saved_is_read_nxt  = saved_is_read_r;
    result             = '0;

    if (item.action == ACT_CMD) begin
      // a command is dropped while a transaction runs
      if (phase_r == PH_IDLE) begin
        saved_is_read_nxt  = item.is_read;
        saved_device_nxt   = item.slave_addr;
        saved_register_nxt = item.reg_ptr;
        saved_data_nxt     = item.write_data;
        bytes_left_nxt     = (item.byte_count == 8'd0) ? 8'd1 : item.byte_count;
        wait_count_nxt     = '0;
        bit_index_nxt      = '0;
        shift_byte_nxt     = '0;
        phase_nxt          = PH_ST1;
      end
    end else if (phase_r >= PH_SEND && phase_r < PH_RLO) begin
      unique case (bit_pos)
        BIT_LO: phase_nxt = phase_r + 6'd1;
        BIT_HI: begin
          if (bit_index_r >= 4'd7) begin
            phase_nxt = phase_r + 6'd1;
          end else begin
            shift_byte_nxt = {shift_byte_r[6:0], 1'b0};
            bit_index_nxt  = bit_index_r + 4'd1;
            phase_nxt      = phase_r - 6'd1;
          end
        end
        ACK_LO: begin
          wait_count_nxt = '0;
          phase_nxt      = phase_r + 6'd1;
        end
        default: begin
          if (!item.sda_in) begin
            bit_index_nxt = '0;
            priority if (slot == SLOT_DEV) begin
              shift_byte_nxt = saved_register_r;
              phase_nxt      = PH_SEND + 6'd4;
            end else if (slot == SLOT_REG && saved_is_read_r) begin
              bit_index_nxt = bit_index_r;
              phase_nxt     = PH_RS1;
            end else if (slot == SLOT_REG) begin
              shift_byte_nxt = saved_data_r;
              phase_nxt      = PH_SEND + 6'd8;
            end else if (slot == SLOT_DATA) begin
              bit_index_nxt = bit_index_r;
              phase_nxt     = PH_P1;
            end else begin
              shift_byte_nxt = '0;
              phase_nxt      = PH_RLO;
            end
          end else if (wait_inc >= {1'b0, ack_timeout_r}) begin
            phase_nxt = PH_E1;
          end else begin
            wait_count_nxt = wait_inc[9:0];
          end
        end
      endcase
    end else begin
      unique case (phase_r)
        PH_IDLE: ;
        PH_ST1, PH_ST2, PH_RS1, PH_RS2, PH_RS3, PH_RLO, PH_MLO, PH_MHI,
        PH_P1, PH_P2, PH_E1, PH_E2:
          phase_nxt = phase_r + 6'd1;
        PH_ST3: begin
          shift_byte_nxt = saved_device_r;
          bit_index_nxt  = '0;
          phase_nxt      = PH_SEND;
        end
        PH_RS4: begin
          shift_byte_nxt = saved_device_r + 8'd1;
          bit_index_nxt  = '0;
          phase_nxt      = PH_SEND + 6'd12;
        end
        PH_RHI: begin
          shift_byte_nxt = rx_shift;
          if (bit_index_r >= 4'd7) begin
            result.read_valid = 1'b1;
            result.read_byte  = rx_shift;
            result.last_byte  = last_left;
            phase_nxt         = PH_MLO;
          end else begin
            bit_index_nxt = bit_index_r + 4'd1;
            phase_nxt     = PH_RLO;
          end
        end
        PH_MEND: begin
          if (last_left) begin
            phase_nxt = PH_P1;
          end else begin
            bytes_left_nxt = bytes_left_r - 8'd1;
            shift_byte_nxt = '0;
            bit_index_nxt  = '0;
            phase_nxt      = PH_RLO;
          end
        end
        PH_P3: begin
          phase_nxt     = PH_IDLE;
          result.status = ST_DONE;
        end
        PH_E3: begin
          phase_nxt     = PH_IDLE;
          result.status = ST_ABORT;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end

    lv = bus_levels(phase_nxt, |(shift_byte_nxt & MSB_MASK), bytes_left_nxt <= 8'd1);
    result.scl_level = lv[1];
    result.sda_level = lv[0];
    result.busy_res  = (phase_nxt != PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r          <= PH_IDLE;
      bit_index_r      <= '0;
      shift_byte_r     <= '0;
      bytes_left_r     <= '0;
      wait_count_r     <= '0;
      saved_device_r   <= '0;
      saved_register_r <= '0;
      saved_data_r     <= '0;
      saved_is_read_r  <= 1'b0;
      ack_timeout_r    <= ACK_TIMEOUT_RESET;
    end else begin
      if (cfg_we) begin
        ack_timeout_r <= cfg_wdata;
      end
      if (step_en) begin
        phase_r          <= phase_nxt;
        bit_index_r      <= bit_index_nxt;
        shift_byte_r     <= shift_byte_nxt;
        bytes_left_r     <= bytes_left_nxt;
        wait_count_r     <= wait_count_nxt;
        saved_device_r   <= saved_device_nxt;
        saved_register_r <= saved_register_nxt;
        saved_data_r     <= saved_data_nxt;
        saved_is_read_r  <= saved_is_read_nxt;
      end
    end
  end

endmodule

// ----- design/i2c_register_master.sv -----
// Top level: input register, phase sequencer and result register with valid/stall handshake.
// An accepted item waits in the input register until it advances into the output register.
// One item per clock while the output is not stalled; the sequencer takes one step per item.
// The input register frees whenever the output register is empty or being taken.
// Reset (rst_n low, synchronous): both stages empty, bus phase idle,
// ack timeout back to 1000.
module i2c_register_master
  import i2cm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic [9:0] cfg_wdata
);

  logic      s1_valid_r;
  in_item_t  s1_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      s1_adv;
  logic      s1_load;
  out_item_t step_res;

  assign s1_adv    = s1_valid_r && !(out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign s1_load   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  i2cm_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .step_en   (s1_adv),
    .item      (s1_data_r),
    .result    (step_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_data_r <= in_data;
    end
    if (s1_adv) begin
      out_data_r <= step_res;
    end
  end

  // ending status only on the transaction that returns to idle
  a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.status != ST_NONE) |-> !out_data_r.busy_res)
    else $error("completion status reported while still busy");

  a_rx_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.read_valid) |-> out_data_r.busy_res)
    else $error("received byte reported outside a transaction");

  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.status != 2'd3))
    else $error("undefined status code");

  a_step_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_valid_r)
    else $error("processed transaction did not reach the output register");

endmodule

// ----- tb/i2c_register_master_test.sv -----
// Self-checking testbench for the tick-driven I2C register master.
`timescale 1ns / 1ps

module i2c_register_master_test;
  import i2cm_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_REPORTS = 10;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  in_item_t   in_data = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  out_item_t  out_data;
  logic       cfg_we = 1'b0;
  logic [9:0] cfg_wdata = '0;

  i2c_register_master dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // bus master state as predicted by the testbench
  logic [PhaseW-1:0] bus_ph;
  logic [3:0]        bit_ix;
  logic [7:0]        shreg;
  logic [7:0]        bytes_rem;
  logic [9:0]        ack_wait;
  logic [7:0]        cmd_dev;
  logic [7:0]        cmd_reg;
  logic [7:0]        cmd_data;
  logic              cmd_rd;
  logic [9:0]        ack_limit;

  out_item_t bus_results_q[$];

  bit tx_idle_en = 1'b0;
  bit rx_idle_en = 1'b0;
  int hold_len = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int checked = 0;
  int work_items = 0;
  int txn_count = 0;
  int read_count = 0;
  int aborts = 0;

  function automatic void load_shift(logic [7:0] value, logic [PhaseW-1:0] nxt);
    shreg  = value;
    bit_ix = '0;
    bus_ph = nxt;
  endfunction

  function automatic out_item_t advance_bus(in_item_t it);
    out_item_t         r;
    logic [PhaseW-1:0] off;
    logic [1:0]        slot;
    logic              nack_bit;
    r = '0;
    if (it.action == ACT_CMD) begin
      if (bus_ph == PH_IDLE) begin
        cmd_rd    = it.is_read;
        cmd_dev   = it.slave_addr;
        cmd_reg   = it.reg_ptr;
        cmd_data  = it.write_data;
        bytes_rem = (it.byte_count == 8'd0) ? 8'd1 : it.byte_count;
        ack_wait  = '0;
        bit_ix    = '0;
        shreg     = '0;
        bus_ph    = PH_ST1;
      end
    end else if (bus_ph >= PH_SEND && bus_ph < PH_RLO) begin
      off  = bus_ph - PH_SEND;
      slot = off[3:2];
      case (off[1:0])
        BIT_LO: bus_ph = bus_ph + 1'b1;
        BIT_HI: begin
          if (bit_ix >= 4'd7) begin
            bus_ph = bus_ph + 1'b1;
          end else begin
            shreg  = shreg << 1;
            bit_ix = bit_ix + 1'b1;
            bus_ph = bus_ph - 1'b1;
          end
        end
        ACK_LO: begin
          ack_wait = '0;
          bus_ph   = bus_ph + 1'b1;
        end
        default: begin
          if (!it.sda_in) begin
            if (slot == SLOT_DEV) load_shift(cmd_reg, PH_SEND + 6'd4);
            else if (slot == SLOT_REG && cmd_rd) bus_ph = PH_RS1;
            else if (slot == SLOT_REG) load_shift(cmd_data, PH_SEND + 6'd8);
            else if (slot == SLOT_DATA) bus_ph = PH_P1;
            else load_shift(8'd0, PH_RLO);
          end else if (int'(ack_wait) + 1 >= int'(ack_limit)) begin
            bus_ph = PH_E1;
          end else begin
            ack_wait = ack_wait + 1'b1;
          end
        end
      endcase
    end else begin
      case (bus_ph)
        PH_IDLE: ;
        PH_ST1, PH_ST2, PH_RS1, PH_RS2, PH_RS3, PH_RLO, PH_MLO, PH_MHI,
        PH_P1, PH_P2, PH_E1, PH_E2: bus_ph = bus_ph + 1'b1;
        PH_ST3: load_shift(cmd_dev, PH_SEND);
        PH_RS4: load_shift(cmd_dev + 8'd1, PH_SEND + 6'd12);
        PH_RHI: begin
          shreg = {shreg[6:0], it.sda_in};
          if (bit_ix >= 4'd7) begin
            r.read_valid = 1'b1;
            r.read_byte  = shreg;
            r.last_byte  = (bytes_rem <= 8'd1);
            bus_ph       = PH_MLO;
          end else begin
            bit_ix = bit_ix + 1'b1;
            bus_ph = PH_RLO;
          end
        end
        PH_MEND: begin
          if (bytes_rem <= 8'd1) begin
            bus_ph = PH_P1;
          end else begin
            bytes_rem = bytes_rem - 1'b1;
            load_shift(8'd0, PH_RLO);
          end
        end
        PH_P3: begin
          bus_ph   = PH_IDLE;
          r.status = ST_DONE;
        end
        PH_E3: begin
          bus_ph   = PH_IDLE;
          r.status = ST_ABORT;
        end
        default: bus_ph = PH_IDLE;
      endcase
    end

    // line levels after the step; the master NACKs only the last read byte
    nack_bit    = (bytes_rem <= 8'd1);
    r.scl_level = 1'b1;
    r.sda_level = 1'b1;
    if (bus_ph >= PH_SEND && bus_ph < PH_RLO) begin
      off = bus_ph - PH_SEND;
      case (off[1:0])
        BIT_LO: begin
          r.scl_level = 1'b0;
          r.sda_level = shreg[7];
        end
        BIT_HI: r.sda_level = shreg[7];
        ACK_LO: r.scl_level = 1'b0;
        default: ;
      endcase
    end else begin
      case (bus_ph)
        PH_ST2, PH_RS3, PH_P2, PH_E2: r.sda_level = 1'b0;
        PH_ST3, PH_RS4, PH_P1, PH_E1: begin
          r.scl_level = 1'b0;
          r.sda_level = 1'b0;
        end
        PH_RS1, PH_RLO: r.scl_level = 1'b0;
        PH_MLO, PH_MEND: begin
          r.scl_level = 1'b0;
          r.sda_level = nack_bit;
        end
        PH_MHI: r.sda_level = nack_bit;
        default: ;
      endcase
    end
    r.busy_res = (bus_ph != PH_IDLE);
    return r;
  endfunction

  function automatic void reset_bus_model();
    bus_ph    = PH_IDLE;
    bit_ix    = '0;
    shreg     = '0;
    bytes_rem = '0;
    ack_wait  = '0;
    cmd_dev   = '0;
    cmd_reg   = '0;
    cmd_data  = '0;
    cmd_rd    = 1'b0;
    ack_limit = ACK_TIMEOUT_RESET;
  endfunction

  function automatic void report_mismatch(string what, out_item_t e, out_item_t g);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: exp scl=%b sda=%b rv=%b byte=%h last=%b busy=%b st=%0d",
               $realtime, what, e.scl_level, e.sda_level, e.read_valid, e.read_byte,
               e.last_byte, e.busy_res, e.status);
      $display("    got scl=%b sda=%b rv=%b byte=%h last=%b busy=%b st=%0d",
               g.scl_level, g.sda_level, g.read_valid, g.read_byte, g.last_byte,
               g.busy_res, g.status);
    end
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (bus_results_q.size() == 0) begin
        report_mismatch("unexpected result", '0, out_data);
      end else begin
        e = bus_results_q.pop_front();
        checked++;
        if (out_data.scl_level !== e.scl_level || out_data.sda_level !== e.sda_level ||
            out_data.read_valid !== e.read_valid || out_data.read_byte !== e.read_byte ||
            out_data.last_byte !== e.last_byte || out_data.busy_res !== e.busy_res ||
            out_data.status !== e.status)
          report_mismatch("mismatch", e, out_data);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, bus_results_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: long hold-off on request, else random stall bursts
  initial begin
    forever begin
      @(posedge clk);
      if (hold_len > 0) begin
        out_stall <= 1'b1;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_stall <= 1'b0;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // prediction is made at offer time; the payload holds until accepted
  task automatic send_item(in_item_t it);
    out_item_t r;
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    if ((it.action == ACT_TICK) == (bus_ph != PH_IDLE)) work_items++;
    r = advance_bus(it);
    if (r.status == ST_ABORT) aborts++;
    bus_results_q.push_back(r);
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall !== 1'b0);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (bus_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_timeout(logic [9:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    ack_limit = value;
  endtask

  function automatic in_item_t random_item();
    logic [63:0] rnd;
    rnd = {$urandom, $urandom};
    return rnd[$bits(in_item_t)-1:0];
  endfunction

  // One command plus ticks until the master is idle again. The slave acks after
  // up to stretch_max high samples, and stops acking from ack slot nack_at on.
  task automatic run_transaction(logic rd, logic [7:0] dev_a, logic [7:0] reg_a,
                                 logic [7:0] wdat, logic [7:0] cnt, int nack_at,
                                 int stretch_max, int busy_cmd_pct, int pause_at);
    in_item_t          it;
    logic [PhaseW-1:0] off;
    int                acks;
    int                stretch;
    int                n;
    it            = random_item();
    it.action     = ACT_CMD;
    it.is_read    = rd;
    it.slave_addr = dev_a;
    it.reg_ptr    = reg_a;
    it.write_data = wdat;
    it.byte_count = cnt;
    send_item(it);
    txn_count++;
    if (rd) read_count++;
    acks    = 0;
    stretch = $urandom_range(0, stretch_max);
    n       = 0;
    while (bus_ph != PH_IDLE) begin
      it  = random_item();
      off = bus_ph - PH_SEND;
      if (busy_cmd_pct > 0 && $urandom_range(0, 99) < busy_cmd_pct) begin
        it.action = ACT_CMD;   // ignored while busy
      end else begin
        it.action = ACT_TICK;
        if (bus_ph >= PH_SEND && bus_ph < PH_RLO && off[1:0] == ACK_HI) begin
          if (acks == nack_at) begin
            it.sda_in = 1'b1;
          end else if (stretch > 0) begin
            it.sda_in = 1'b1;
            stretch--;
          end else begin
            it.sda_in = 1'b0;
            acks++;
            stretch = $urandom_range(0, stretch_max);
          end
        end
      end
      if (n == pause_at) wait_drained();
      send_item(it);
      n++;
    end
  endtask

  task automatic test_idle_ticks();
    in_item_t it;
    repeat (4) begin
      it        = random_item();
      it.action = ACT_TICK;
      send_item(it);
    end
  endtask

  task automatic test_writes();
    run_transaction(1'b0, 8'h00, 8'hFF, 8'h00, 8'h00, -1, 0, 0, -1);
    run_transaction(1'b0, 8'hFF, 8'h00, 8'hFF, 8'hFF, -1, 0, 0, -1);
    run_transaction(1'b0, 8'hA4, 8'h5A, 8'hC3, 8'h01, -1, 2, 0, -1);
  endtask

  task automatic test_reads();
    run_transaction(1'b1, 8'h00, 8'h12, 8'h00, 8'd1, -1, 0, 0, -1);
    // zero count reads a single byte
    run_transaction(1'b1, 8'hFE, 8'hFF, 8'hFF, 8'd0, -1, 1, 0, -1);
    // device FF wraps to 00 for the read address
    run_transaction(1'b1, 8'hFF, 8'hAA, 8'h55, 8'd4, -1, 0, 0, -1);
  endtask

  task automatic test_busy_commands();
    run_transaction(1'b0, 8'h90, 8'h21, 8'h7E, 8'd2, -1, 1, 30, -1);
  endtask

  task automatic test_nack_aborts();
    set_timeout(10'd1);
    run_transaction(1'b1, 8'h50, 8'h01, 8'h02, 8'd2, 2, 0, 0, -1);
    run_transaction(1'b0, 8'h50, 8'h03, 8'h04, 8'd1, 2, 0, 0, -1);
    // zero acts like one
    set_timeout(10'd0);
    run_transaction(1'b0, 8'h52, 8'h05, 8'h06, 8'd1, 1, 0, 0, -1);
    set_timeout(10'd2);
    run_transaction(1'b1, 8'h54, 8'h07, 8'h08, 8'd1, -1, 1, 0, -1);
    set_timeout(10'd1023);
    run_transaction(1'b1, 8'h56, 8'h09, 8'h0A, 8'd2, -1, 3, 0, -1);
  endtask

  task automatic test_backpressure();
    rx_idle_en = 1'b0;
    // receiver holds off long enough that the input side stalls
    hold_len = 60;
    run_transaction(1'b0, 8'h6A, 8'h33, 8'hCC, 8'd1, -1, 0, 0, -1);
    // sender waits mid-transaction for every result to come back
    run_transaction(1'b1, 8'h6A, 8'h34, 8'h00, 8'd2, -1, 1, 0, 25);
    rx_idle_en = 1'b1;
  endtask

  task automatic test_random(int budget);
    int       start;
    int       nack_at;
    logic     rd;
    logic [7:0] cnt;
    logic [9:0] tmo;
    in_item_t it;
    start = work_items;
    while (work_items - start < budget) begin
      if (work_items - start >= budget - budget / 6) begin
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
      end
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 9))
          0: tmo = 10'd0;
          1: tmo = 10'd1;
          2: tmo = 10'd1023;
          default: tmo = 10'($urandom_range(2, 16));
        endcase
        set_timeout(tmo);
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          it        = random_item();
          it.action = ACT_TICK;
          send_item(it);
        end
      end
      rd = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
        0, 1:    cnt = 8'd0;
        2:       cnt = 8'($urandom_range(4, 20));
        default: cnt = 8'($urandom_range(1, 3));
      endcase
      nack_at = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2) : -1;
      // keep long timeouts from eating the item budget
      if (ack_limit > 10'd16) nack_at = -1;
      run_transaction(rd, 8'($urandom), 8'($urandom), 8'($urandom), cnt, nack_at,
                      $urandom_range(0, 3), ($urandom_range(0, 3) == 0) ? 5 : 0, -1);
    end
  endtask

  initial begin
    reset_bus_model();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    test_idle_ticks();
    test_writes();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    test_reads();
    test_busy_commands();
    test_nack_aborts();
    test_backpressure();
    test_random(200);

    wait_drained();
    repeat (4) @(posedge clk);
    if (bus_results_q.size() != 0) mismatches += bus_results_q.size();

    $display("Ran %0d bus transactions (%0d reads, %0d aborted) from %0d working items",
             txn_count, read_count, aborts, work_items);
    $display("Checked %0d results against the prediction, %0d mismatches", checked, mismatches);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- i2c_register_master.f -----
design/i2cm_pkg.sv
design/i2cm_engine.sv
design/i2c_register_master.sv
tb/i2c_register_master_test.sv
